[hw/rtl/otq_pkg.sv]
// ----------------------------------------------------------------------------
// otq_pkg
// Shared codes and types for the one-shot timer queue: command codes, result
// kinds and the operation that the cell row carries out in a cycle.
// ----------------------------------------------------------------------------
package otq_pkg;

    localparam int EXPIRY_BITS = 32;

    typedef logic [EXPIRY_BITS-1:0] expiry_t;
    typedef logic [2:0]             kind_t;
    typedef logic [1:0]             cell_op_t;

    // command codes
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_EXPIRE = 1'b1;

    // result kinds
    localparam kind_t KIND_ARM      = 3'd0;
    localparam kind_t KIND_NOCHANGE = 3'd1;
    localparam kind_t KIND_FIRED    = 3'd2;
    localparam kind_t KIND_IDLE     = 3'd3;
    localparam kind_t KIND_FULL     = 3'd4;

    // cell row operations
    localparam cell_op_t OP_HOLD   = 2'd0;
    localparam cell_op_t OP_INSERT = 2'd1;
    localparam cell_op_t OP_SHIFT  = 2'd2;

endpackage

[hw/rtl/otq_if.sv]
// ----------------------------------------------------------------------------
// otq interfaces
// Valid/ready channels of the timer queue: the command word channel and the
// result word channel.
// ----------------------------------------------------------------------------
interface otq_req_if
    import otq_pkg::*;
#(
    parameter int HANDLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    expiry_t                expiry;
    logic [HANDLE_BITS-1:0] timer_handle;
    expiry_t                now;

    modport source (output valid, output cmd, output expiry, output timer_handle,
                    output now, input ready);
    modport sink   (input valid, input cmd, input expiry, input timer_handle,
                    input now, output ready);
endinterface

interface otq_rsp_if
    import otq_pkg::*;
#(
    parameter int HANDLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    kind_t                  kind;
    logic [HANDLE_BITS-1:0] fired_handle;
    expiry_t                arm_time;
    logic                   last;

    modport source (output valid, output kind, output fired_handle,
                    output arm_time, output last, input ready);
    modport sink   (input valid, input kind, input fired_handle,
                    input arm_time, input last, output ready);
endinterface

[hw/rtl/otq_cell.sv]
// ----------------------------------------------------------------------------
// otq_cell
// One slot of the sorted timer row. Holds a timer, compares it against the timer being
// inserted, takes its left neighbour or the new timer on an insert, its right one on a shift.
// ----------------------------------------------------------------------------
module otq_cell
    import otq_pkg::*;
#(
    parameter int HANDLE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cell_op_t               op,
    input  expiry_t                new_expiry,
    input  logic [HANDLE_BITS-1:0] new_handle,
    input  logic                   prev_valid,
    input  expiry_t                prev_expiry,
    input  logic [HANDLE_BITS-1:0] prev_handle,
    input  logic                   prev_ins,
    input  logic                   next_valid,
    input  expiry_t                next_expiry,
    input  logic [HANDLE_BITS-1:0] next_handle,
    output logic                   valid,
    output expiry_t                expiry,
    output logic [HANDLE_BITS-1:0] handle,
    output logic                   ins
);

    logic                   valid_reg;
    logic                   valid_next;
    expiry_t                expiry_reg;
    expiry_t                expiry_next;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [HANDLE_BITS-1:0] handle_next;

    // new timer goes at or before this slot (on a tie it goes behind this slot)
    assign ins = !valid_reg || (expiry_reg > new_expiry);

    always_comb
    begin
        valid_next  = valid_reg;
        expiry_next = expiry_reg;
        handle_next = handle_reg;
        unique case (op)
            OP_INSERT:
            begin
                if (ins)
                begin
                    if (prev_ins)
                    begin
                        valid_next  = prev_valid;
                        expiry_next = prev_expiry;
                        handle_next = prev_handle;
                    end
                    else
                    begin
                        valid_next  = 1'b1;
                        expiry_next = new_expiry;
                        handle_next = new_handle;
                    end
                end
            end
            OP_SHIFT:
            begin
                valid_next  = next_valid;
                expiry_next = next_expiry;
                handle_next = next_handle;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        expiry_reg <= expiry_next;
        handle_reg <= handle_next;
    end

    assign valid  = valid_reg;
    assign expiry = expiry_reg;
    assign handle = handle_reg;

endmodule

[hw/rtl/one_shot_timer_queue.sv]
// ----------------------------------------------------------------------------
// one_shot_timer_queue
// Sorted one-shot timer queue built as a row of DEPTH cells kept in expiry
// order; the head cell drives the hardware compare.
// ----------------------------------------------------------------------------
// start word: inserted in the accept cycle, result word registered
// expire word: now is sampled on accept, then each due timer leaves through the
//   head cell as a fired word, and a final word ends the sequence
// one word in flight at a time; the head-of-row shift sets the expire pace while results are taken
// reset empties the row at once (cell valid bits cleared), no clearing pass
// ----------------------------------------------------------------------------
module one_shot_timer_queue
    import otq_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int HANDLE_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    otq_req_if.sink   req,
    otq_rsp_if.source rsp
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_EXPIRE = 1'b1;

    logic                   state_reg;
    logic                   state_next;
    expiry_t                now_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    kind_t                  kind_reg;
    kind_t                  kind_next;
    logic [HANDLE_BITS-1:0] fired_reg;
    logic [HANDLE_BITS-1:0] fired_next;
    expiry_t                arm_reg;
    expiry_t                arm_next;
    logic                   last_reg;
    logic                   last_next;

    logic                   cell_valid [DEPTH];
    expiry_t                cell_expiry [DEPTH];
    logic [HANDLE_BITS-1:0] cell_handle [DEPTH];
    logic                   cell_ins [DEPTH];
    logic [DEPTH-1:0]       valid_vec;

    cell_op_t op;
    logic     load_ok;
    logic     accept;
    logic     full;
    logic     head_due;
    logic     load_result;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                   p_valid;
            expiry_t                p_expiry;
            logic [HANDLE_BITS-1:0] p_handle;
            logic                   p_ins;
            logic                   n_valid;
            expiry_t                n_expiry;
            logic [HANDLE_BITS-1:0] n_handle;

            if (i == 0)
            begin : g_first
                assign p_valid  = 1'b0;
                assign p_expiry = '0;
                assign p_handle = '0;
                assign p_ins    = 1'b0;
            end
            else
            begin : g_mid
                assign p_valid  = cell_valid[i-1];
                assign p_expiry = cell_expiry[i-1];
                assign p_handle = cell_handle[i-1];
                assign p_ins    = cell_ins[i-1];
            end

            if (i == DEPTH-1)
            begin : g_end
                assign n_valid  = 1'b0;
                assign n_expiry = '0;
                assign n_handle = '0;
            end
            else
            begin : g_body
                assign n_valid  = cell_valid[i+1];
                assign n_expiry = cell_expiry[i+1];
                assign n_handle = cell_handle[i+1];
            end

            otq_cell #(
                .HANDLE_BITS (HANDLE_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (op),
                .new_expiry  (req.expiry),
                .new_handle  (req.timer_handle),
                .prev_valid  (p_valid),
                .prev_expiry (p_expiry),
                .prev_handle (p_handle),
                .prev_ins    (p_ins),
                .next_valid  (n_valid),
                .next_expiry (n_expiry),
                .next_handle (n_handle),
                .valid       (cell_valid[i]),
                .expiry      (cell_expiry[i]),
                .handle      (cell_handle[i]),
                .ins         (cell_ins[i])
            );

            assign valid_vec[i] = cell_valid[i];
        end
    endgenerate

    assign load_ok   = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && load_ok;
    assign accept    = req.valid && req.ready;
    assign full      = cell_valid[DEPTH-1];
    assign head_due  = cell_valid[0] && (cell_expiry[0] <= now_reg);

    always_comb
    begin
        op          = OP_HOLD;
        state_next  = state_reg;
        load_result = 1'b0;
        kind_next   = kind_reg;
        fired_next  = fired_reg;
        arm_next    = arm_reg;
        last_next   = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd == CMD_START)
                    begin
                        load_result = 1'b1;
                        fired_next  = '0;
                        arm_next    = '0;
                        last_next   = 1'b1;
                        if (full)
                        begin
                            kind_next = KIND_FULL;
                        end
                        else
                        begin
                            op = OP_INSERT;
                            if (cell_ins[0])
                            begin
                                kind_next = KIND_ARM;
                                arm_next  = req.expiry;
                            end
                            else
                            begin
                                kind_next = KIND_NOCHANGE;
                            end
                        end
                    end
                    else
                    begin
                        state_next = ST_EXPIRE;
                    end
                end
            end
            ST_EXPIRE:
            begin
                if (load_ok)
                begin
                    load_result = 1'b1;
                    fired_next  = '0;
                    arm_next    = '0;
                    if (head_due)
                    begin
                        op         = OP_SHIFT;
                        kind_next  = KIND_FIRED;
                        fired_next = cell_handle[0];
                        last_next  = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        last_next  = 1'b1;
                        if (cell_valid[0])
                        begin
                            kind_next = KIND_ARM;
                            arm_next  = cell_expiry[0];
                        end
                        else
                        begin
                            kind_next = KIND_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= req.now;
        end
        kind_reg  <= kind_next;
        fired_reg <= fired_next;
        arm_reg   <= arm_next;
        last_reg  <= last_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.kind         = kind_reg;
    assign rsp.fired_handle = fired_reg;
    assign rsp.arm_time     = arm_reg;
    assign rsp.last         = last_reg;

    // held timers stay packed at the head of the row
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (((valid_vec >> 1) & ~valid_vec) == '0))
        else $error("timer row has a gap");

    // an insert adds exactly one timer
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_INSERT) |=> ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
        else $error("insert did not add one timer");

    // a fired word is only shown while its expire sequence is still running
    a_fired_in_expire: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_FIRED)) |-> (state_reg == ST_EXPIRE))
        else $error("fired word outside expire sequence");

    // a rejected start leaves the row unchanged
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.cmd == CMD_START) && full) |=> $stable(valid_vec))
        else $error("full table changed on rejected start");

endmodule
